@@ hdl/tnb_pkg.sv @@
package tnb_pkg;

    // Fixed field widths
    localparam int NODE_COUNT_W = 7;
    localparam int MARK_W       = 2;
    localparam int LB_W         = 22;
    // lower_bound is bits [LB_W:1] of (sum + 1), so the sum is kept modulo 2**(LB_W+1)
    localparam int SUM_W        = LB_W + 1;

    localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RESET = 7'd4;

    // Edge marks; the unused code is treated as excluded
    localparam logic [MARK_W-1:0] MARK_EXCLUDED = 2'd0;
    localparam logic [MARK_W-1:0] MARK_FREE     = 2'd1;
    localparam logic [MARK_W-1:0] MARK_INCLUDED = 2'd2;

    // Control that travels with one element
    typedef struct packed {
        logic valid;
        logic row_end;
        logic mat_end;
    } item_ctl_t;

    // Control and flags of one closed row
    typedef struct packed {
        logic valid;
        logic mat_end;
        logic feasible;
        logic present;
    } row_res_t;

endpackage

@@ hdl/tnb_edge_if.sv @@
interface tnb_edge_if #(
    parameter int COST_BITS = 16
);
    import tnb_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [MARK_W-1:0]     edge_mark;
    logic [COST_BITS-1:0]  edge_cost;

    modport source (output valid, output edge_mark, output edge_cost, input ready);
    modport sink   (input valid, input edge_mark, input edge_cost, output ready);
endinterface

@@ hdl/tnb_bound_if.sv @@
interface tnb_bound_if;
    import tnb_pkg::*;

    logic             valid;
    logic             ready;
    logic [LB_W-1:0]  lower_bound;
    logic             feasible;
    logic             bound_valid;

    modport source (output valid, output lower_bound, output feasible, output bound_valid,
                    input ready);
    modport sink   (input valid, input lower_bound, input feasible, input bound_valid,
                    output ready);
endinterface

@@ hdl/tnb_cfg_if.sv @@
interface tnb_cfg_if;
    import tnb_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [NODE_COUNT_W-1:0]  node_count;

    modport source (output valid, output node_count, input ready);
    modport sink   (input valid, input node_count, output ready);
endinterface

@@ hdl/tour_node_bound_and_feasibility.sv @@
// The last element moves via input, snapshot and row result registers into bound.valid.
// Throughput: one element transaction per cycle; the input stalls only while a
//   finished result waits on bound and another matrix end is in flight.
// Reset (rst_n, async, active low): node_count returns to 4, indexes, row state and
//   sums clear, the result register empties.
module tour_node_bound_and_feasibility #(
    parameter int MAX_NODES = 64,
    parameter int COST_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    tnb_cfg_if.sink       cfg,
    tnb_edge_if.sink      edges,
    tnb_bound_if.source   bound
);
    import tnb_pkg::*;

    localparam int IDX_W   = $clog2(MAX_NODES);
    localparam int SIDE_W  = $clog2(MAX_NODES + 1);
    localparam int CMP_W   = (SIDE_W > NODE_COUNT_W) ? SIDE_W : NODE_COUNT_W;

    // Configuration
    logic [NODE_COUNT_W-1:0]  node_count_reg;
    logic [CMP_W-1:0]         node_ext;
    logic [IDX_W-1:0]         last_idx;

    // Element indexes
    logic [IDX_W-1:0]         col_reg;
    logic [IDX_W-1:0]         row_reg;
    logic                     row_end_now;
    logic                     mat_end_now;
    logic                     edge_acc;

    // Input register
    item_ctl_t                item_ctl_reg;
    logic [1:0]               mark_reg;
    logic [COST_BITS-1:0]     cost_reg;

    // Row closing
    row_res_t                 row_res;
    logic [COST_BITS:0]       row_terms;
    logic                     row_end_pending;

    // Sum over rows and result register
    logic [SUM_W-1:0]         sum_reg, sum_next;
    logic                     feas_reg, feas_next;
    logic                     pres_reg, pres_next;
    logic [SUM_W-1:0]         round_sum;
    logic                     out_valid_reg;
    logic [LB_W-1:0]          lb_reg;
    logic                     out_feas_reg;
    logic                     out_pres_reg;

    logic                     end_pending;
    logic                     advance;

    // Configuration is always taken
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RESET;
        end
        else if (cfg.valid)
        begin
            node_count_reg <= cfg.node_count;
        end
    end

    // Zero acts as one city, anything above MAX_NODES as MAX_NODES
    assign node_ext = CMP_W'(node_count_reg);

    always_comb
    begin
        if (node_ext == '0)
        begin
            last_idx = '0;
        end
        else if (node_ext > CMP_W'(MAX_NODES))
        begin
            last_idx = IDX_W'(MAX_NODES - 1);
        end
        else
        begin
            last_idx = IDX_W'(node_ext - CMP_W'(1));
        end
    end

    // The whole pipeline advances on one enable: input register, row update, row close,
    // sum and result register.
    // Hold everything only when a result would land on an untaken one
    assign end_pending = (item_ctl_reg.valid && item_ctl_reg.mat_end) || row_end_pending;
    assign advance     = !out_valid_reg || bound.ready || !end_pending;
    assign edges.ready = advance;
    assign edge_acc    = edges.valid && advance;

    assign row_end_now = !(col_reg < last_idx);
    assign mat_end_now = row_end_now && !(row_reg < last_idx);

    // Advance the column, then the row; wrap both at the matrix end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (edge_acc)
        begin
            if (!row_end_now)
            begin
                col_reg <= col_reg + IDX_W'(1);
            end
            else
            begin
                col_reg <= '0;
                if (mat_end_now)
                begin
                    row_reg <= '0;
                end
                else
                begin
                    row_reg <= row_reg + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_ctl_reg <= '0;
        end
        else if (advance)
        begin
            item_ctl_reg.valid   <= edges.valid;
            item_ctl_reg.row_end <= row_end_now;
            item_ctl_reg.mat_end <= mat_end_now;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mark_reg <= edges.edge_mark;
            cost_reg <= edges.edge_cost;
        end
    end

    tnb_row_acc #(
        .COST_BITS (COST_BITS)
    ) u_row_acc (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .item_ctl    (item_ctl_reg),
        .item_mark   (mark_reg),
        .item_cost   (cost_reg),
        .row_res     (row_res),
        .row_terms   (row_terms),
        .end_pending (row_end_pending)
    );

    // Fold the closed row into the node totals; only the low SUM_W bits matter
    assign sum_next  = sum_reg + SUM_W'(row_terms);
    assign feas_next = feas_reg && row_res.feasible;
    assign pres_next = pres_reg && row_res.present;
    assign round_sum = sum_next + SUM_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            feas_reg      <= 1'b1;
            pres_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance && row_res.valid)
            begin
                if (row_res.mat_end)
                begin
                    sum_reg  <= '0;
                    feas_reg <= 1'b1;
                    pres_reg <= 1'b1;
                end
                else
                begin
                    sum_reg  <= sum_next;
                    feas_reg <= feas_next;
                    pres_reg <= pres_next;
                end
            end
            if (advance && row_res.valid && row_res.mat_end)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (bound.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Ceiling of half the sum
    always_ff @(posedge clk)
    begin
        if (advance && row_res.valid && row_res.mat_end)
        begin
            lb_reg       <= round_sum[SUM_W-1:1];
            out_feas_reg <= feas_next;
            out_pres_reg <= pres_next;
        end
    end

    assign bound.valid       = out_valid_reg;
    assign bound.lower_bound = lb_reg;
    assign bound.feasible    = out_feas_reg;
    assign bound.bound_valid = out_pres_reg;

    // Input holds only while a result sits untaken
    assert property (@(posedge clk) disable iff (!rst_n)
        !edges.ready |-> (out_valid_reg && !bound.ready))
        else $error("input stalled without a waiting result");

    // A result appears only from a closed last row
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(row_res.valid && row_res.mat_end))
        else $error("result without a matrix end");

    // Mid-row transactions step the column by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (edge_acc && !row_end_now) |=> (col_reg == $past(col_reg) + IDX_W'(1)))
        else $error("column index did not advance");

    // Matrix end wraps both indexes
    assert property (@(posedge clk) disable iff (!rst_n)
        (edge_acc && mat_end_now) |=> (col_reg == '0 && row_reg == '0))
        else $error("indexes not cleared at matrix end");

endmodule

@@ hdl/tnb_row_acc.sv @@
module tnb_row_acc #(
    parameter int COST_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  tnb_pkg::item_ctl_t    item_ctl,
    input  logic [1:0]            item_mark,
    input  logic [COST_BITS-1:0]  item_cost,
    output tnb_pkg::row_res_t     row_res,
    output logic [COST_BITS:0]    row_terms,
    output logic                  end_pending
);
    import tnb_pkg::*;

    localparam int FREE_W = COST_BITS + 1;
    localparam logic [FREE_W-1:0] FREE_NONE = '1;

    // Running row state
    logic [1:0]            inc_cnt_reg, inc_cnt_next;
    logic [1:0]            free_cnt_reg, free_cnt_next;
    logic [COST_BITS-1:0]  first_inc_reg, first_inc_next;
    logic [COST_BITS-1:0]  second_inc_reg, second_inc_next;
    logic [FREE_W-1:0]     cheap_reg, cheap_next;
    logic [FREE_W-1:0]     cheap2_reg, cheap2_next;

    // Snapshot of a closed row
    logic                  snap_valid_reg;
    logic                  snap_end_reg;
    logic [1:0]            snap_inc_reg;
    logic [1:0]            snap_free_reg;
    logic [COST_BITS-1:0]  snap_first_reg;
    logic [COST_BITS-1:0]  snap_second_reg;
    logic [FREE_W-1:0]     snap_cheap_reg;
    logic [FREE_W-1:0]     snap_cheap2_reg;

    // Closed-row terms
    row_res_t              row_res_reg, row_res_next;
    logic [COST_BITS:0]    row_terms_reg, row_terms_next;

    logic [FREE_W-1:0]     cost_ext;
    logic [COST_BITS-1:0]  term1, term2;
    logic                  term1_ok, term2_ok;
    logic [2:0]            deg_sum;

    assign cost_ext = FREE_W'(item_cost);

    always_comb
    begin
        inc_cnt_next    = inc_cnt_reg;
        free_cnt_next   = free_cnt_reg;
        first_inc_next  = first_inc_reg;
        second_inc_next = second_inc_reg;
        cheap_next      = cheap_reg;
        cheap2_next     = cheap2_reg;
        case (item_mark)
            MARK_INCLUDED:
            begin
                if (inc_cnt_reg == 2'd0)
                begin
                    first_inc_next = item_cost;
                end
                else if (inc_cnt_reg == 2'd1)
                begin
                    second_inc_next = item_cost;
                end
                if (inc_cnt_reg != 2'd3)
                begin
                    inc_cnt_next = inc_cnt_reg + 2'd1;
                end
            end
            MARK_FREE:
            begin
                if (cost_ext < cheap_reg)
                begin
                    cheap2_next = cheap_reg;
                    cheap_next  = cost_ext;
                end
                else if (cost_ext < cheap2_reg)
                begin
                    cheap2_next = cost_ext;
                end
                if (free_cnt_reg != 2'd3)
                begin
                    free_cnt_next = free_cnt_reg + 2'd1;
                end
            end
            default:
            begin
                inc_cnt_next = inc_cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inc_cnt_reg    <= 2'd0;
            free_cnt_reg   <= 2'd0;
            first_inc_reg  <= '0;
            second_inc_reg <= '0;
            cheap_reg      <= FREE_NONE;
            cheap2_reg     <= FREE_NONE;
            snap_valid_reg <= 1'b0;
            snap_end_reg   <= 1'b0;
        end
        else if (advance)
        begin
            snap_valid_reg <= item_ctl.valid && item_ctl.row_end;
            snap_end_reg   <= item_ctl.mat_end;
            if (item_ctl.valid && item_ctl.row_end)
            begin
                inc_cnt_reg    <= 2'd0;
                free_cnt_reg   <= 2'd0;
                first_inc_reg  <= '0;
                second_inc_reg <= '0;
                cheap_reg      <= FREE_NONE;
                cheap2_reg     <= FREE_NONE;
            end
            else if (item_ctl.valid)
            begin
                inc_cnt_reg    <= inc_cnt_next;
                free_cnt_reg   <= free_cnt_next;
                first_inc_reg  <= first_inc_next;
                second_inc_reg <= second_inc_next;
                cheap_reg      <= cheap_next;
                cheap2_reg     <= cheap2_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            snap_inc_reg    <= inc_cnt_next;
            snap_free_reg   <= free_cnt_next;
            snap_first_reg  <= first_inc_next;
            snap_second_reg <= second_inc_next;
            snap_cheap_reg  <= cheap_next;
            snap_cheap2_reg <= cheap2_next;
        end
    end

    // Pick the two terms of the closed row
    always_comb
    begin
        term1    = '0;
        term2    = '0;
        term1_ok = 1'b1;
        term2_ok = 1'b1;
        if (snap_inc_reg != 2'd0)
        begin
            term1 = snap_first_reg;
        end
        else if (snap_free_reg != 2'd0)
        begin
            term1 = snap_cheap_reg[COST_BITS-1:0];
        end
        else
        begin
            term1_ok = 1'b0;
        end

        if (snap_inc_reg >= 2'd2)
        begin
            term2 = snap_second_reg;
        end
        else if (snap_inc_reg == 2'd1)
        begin
            if (snap_free_reg != 2'd0)
            begin
                term2 = snap_cheap_reg[COST_BITS-1:0];
            end
            else
            begin
                term2_ok = 1'b0;
            end
        end
        else if (snap_free_reg >= 2'd2)
        begin
            term2 = snap_cheap2_reg[COST_BITS-1:0];
        end
        else
        begin
            term2_ok = 1'b0;
        end

        deg_sum = {1'b0, snap_inc_reg} + {1'b0, snap_free_reg};

        row_terms_next        = {1'b0, term1} + {1'b0, term2};
        row_res_next.valid    = snap_valid_reg;
        row_res_next.mat_end  = snap_end_reg;
        row_res_next.feasible = (deg_sum >= 3'd2) && (snap_inc_reg != 2'd3);
        row_res_next.present  = term1_ok && term2_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_res_reg <= '0;
        end
        else if (advance)
        begin
            row_res_reg <= row_res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            row_terms_reg <= row_terms_next;
        end
    end

    assign row_res     = row_res_reg;
    assign row_terms   = row_terms_reg;
    assign end_pending = (snap_valid_reg && snap_end_reg)
                       || (row_res_reg.valid && row_res_reg.mat_end);

endmodule
